/* sv/dltq_pkg.sv */
// ----------------------------------------------------------------------------
// dltq_pkg: shared types and constants for the delta-list timer queue
// Holds field widths, status/kind codes and the sequencer state type.
// ----------------------------------------------------------------------------
package dltq_pkg;

    localparam int DefPoolSlots = 32;
    localparam int MaxResults   = 32;

    localparam logic [1:0] StatusOk   = 2'd0;
    localparam logic [1:0] StatusZero = 2'd1;
    localparam logic [1:0] StatusFull = 2'd2;

    localparam logic KindReply  = 1'b0;
    localparam logic KindExpiry = 1'b1;

    localparam logic ReqTick  = 1'b0;
    localparam logic ReqSched = 1'b1;

    typedef enum logic [11:0] {
        ST_INIT  = 12'b000000000001,
        ST_IDLE  = 12'b000000000010,
        ST_SRD   = 12'b000000000100,
        ST_SHEAD = 12'b000000001000,
        ST_WALK  = 12'b000000010000,
        ST_WCHK  = 12'b000000100000,
        ST_SFIX  = 12'b000001000000,
        ST_TRD   = 12'b000010000000,
        ST_TCHK  = 12'b000100000000,
        ST_TOUT  = 12'b001000000000,
        ST_TWAIT = 12'b010000000000,
        ST_REPLY = 12'b100000000000
    } state_t;

    typedef struct packed {
        logic       kind;
        logic [1:0] status;
        logic [4:0] slot;
        logic [31:0] etag;
        logic       last;
    } result_t;

endpackage

/* sv/dltq_mem.sv */
// ----------------------------------------------------------------------------
// dltq_mem: slot storage
// Synchronous memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module dltq_mem
    import dltq_pkg::*;
#(
    parameter int Width = 32,
    parameter int Depth = DefPoolSlots,
    localparam int AW = $clog2(Depth)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [Width-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [Width-1:0] rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/delta_list_timer_queue_core.sv */
// ----------------------------------------------------------------------------
// delta_list_timer_queue_core: one-shot timer engine over a slot pool
// Delta-list timer queue with free list, kept in slot memories.
// ----------------------------------------------------------------------------
// Usage: s_ beats carry a request: tuser = req_type (1 = schedule, 0 = tick),
// tdata = {tag, delay_ms}. A schedule gives one reply beat (kind 0) with its
// status and slot. A tick decrements the head delta and gives one expiry beat
// (kind 1) per timer that reaches zero, at most 32, or no beat at all.
// m_tlast marks the final beat of a request. m_tuser = kind.
// m_tdata = status, slot, expired_tag from the lowest bit up.
// Flow: one request at a time; s_tready rises again once the final result
// beat has left. A schedule reads the link and delta memories for each list
// entry that it passes before its reply is valid.
// Reset: a clearing pass writes the free-list links; s_tready stays low
// meanwhile. A stalled m_ side holds the output register and the expiry
// walk and s_tready wait for it.
// ----------------------------------------------------------------------------
module delta_list_timer_queue_core
    import dltq_pkg::*;
#(
    parameter int POOL_SLOTS = DefPoolSlots,
    localparam int AW = $clog2(POOL_SLOTS),
    localparam int LW = AW + 1
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // delay_ms[31:0], tag[63:32]
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[1:0], slot[6:2], expired_tag[38:7]
    output logic        m_tuser,   // kind
    output logic        m_tlast    // last
);

    localparam logic [LW-1:0] Nil = LW'(POOL_SLOTS);

    state_t state_reg, state_next;
    logic [LW-1:0] qhead_reg, qhead_next, fhead_reg, fhead_next;
    logic [LW-1:0] cur_reg, cur_next, nxt_reg, nxt_next, slot_reg, slot_next;
    logic [31:0]   ms_reg, ms_next, tag_reg, tag_next, raw_reg, raw_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic          ovalid_reg, ovalid_next;
    result_t       out_reg, out_next;

    logic          l_we, d_we, t_we;
    logic [AW-1:0] l_wa, d_wa, t_wa, l_ra, d_ra, t_ra;
    logic [LW-1:0] l_wd, l_rd;
    logic [31:0]   d_wd, d_rd, t_wd, t_rd;
    logic [32:0]   sum;

    dltq_mem #(.Width(LW), .Depth(POOL_SLOTS)) u_link (
        .aclk(aclk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
    dltq_mem #(.Width(32), .Depth(POOL_SLOTS)) u_delta (
        .aclk(aclk), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd));
    dltq_mem #(.Width(32), .Depth(POOL_SLOTS)) u_tag (
        .aclk(aclk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));

    wire out_free = !ovalid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE) && !ovalid_reg;
    assign m_tvalid = ovalid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {1'b0, out_reg.etag, out_reg.slot, out_reg.status};
    assign sum      = {1'b0, raw_reg} + {1'b0, d_rd};

    always_comb begin
        state_next = state_reg;
        qhead_next = qhead_reg;
        fhead_next = fhead_reg;
        cur_next = cur_reg;
        nxt_next = nxt_reg;
        slot_next = slot_reg;
        ms_next = ms_reg;
        tag_next = tag_reg;
        raw_next = raw_reg;
        cnt_next = cnt_reg;
        ovalid_next = ovalid_reg && !m_tready;
        out_next = out_reg;
        l_we = 1'b0; l_wa = cur_reg[AW-1:0]; l_wd = Nil;
        d_we = 1'b0; d_wa = slot_reg[AW-1:0]; d_wd = ms_reg;
        t_we = 1'b0; t_wa = slot_reg[AW-1:0]; t_wd = tag_reg;
        l_ra = cur_reg[AW-1:0];
        d_ra = cur_reg[AW-1:0];
        t_ra = cur_reg[AW-1:0];
        case (state_reg)
            ST_INIT: begin
                l_we = 1'b1;
                l_wd = cur_reg + 1'b1;
                cur_next = cur_reg + 1'b1;
                if (cur_reg == Nil - 1'b1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    ms_next = s_tdata[31:0];
                    tag_next = s_tdata[63:32];
                    cnt_next = '0;
                    if (s_tuser == ReqSched) begin
                        out_next = '{KindReply, StatusOk, '0, '0, 1'b1};
                        if (s_tdata[31:0] == '0) begin
                            out_next.status = StatusZero;
                            state_next = ST_REPLY;
                        end else if (fhead_reg == Nil) begin
                            out_next.status = StatusFull;
                            state_next = ST_REPLY;
                        end else begin
                            slot_next = fhead_reg;
                            cur_next = fhead_reg;
                            out_next.slot = 5'(fhead_reg);
                            state_next = ST_SRD;
                        end
                    end else if (qhead_reg != Nil) begin
                        cur_next = qhead_reg;
                        state_next = ST_TRD;
                    end
                end
            end
            ST_SRD: begin
                // read free link of new slot and delta of head; write tag of new slot
                l_ra = slot_reg[AW-1:0];
                d_ra = qhead_reg[AW-1:0];
                t_we = 1'b1;
                state_next = ST_SHEAD;
            end
            ST_SHEAD: begin
                fhead_next = l_rd;
                if (qhead_reg == Nil) begin
                    d_we = 1'b1;
                    l_we = 1'b1; l_wa = slot_reg[AW-1:0]; l_wd = Nil;
                    qhead_next = slot_reg;
                    state_next = ST_REPLY;
                end else if (ms_reg < d_rd) begin
                    d_we = 1'b1;
                    d_ra = qhead_reg[AW-1:0];
                    l_we = 1'b1; l_wa = slot_reg[AW-1:0]; l_wd = qhead_reg;
                    nxt_next = qhead_reg;
                    raw_next = '0;
                    qhead_next = slot_reg;
                    state_next = ST_SFIX;
                end else begin
                    raw_next = d_rd;
                    cur_next = qhead_reg;
                    cnt_next = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                l_ra = cur_reg[AW-1:0];
                state_next = ST_WCHK;
                nxt_next = Nil;
            end
            ST_WCHK: begin
                // l_rd = link[cur]; read delta[nxt] next
                if (nxt_reg == Nil) begin
                    nxt_next = l_rd;
                    d_ra = l_rd[AW-1:0];
                    if (l_rd == Nil || cnt_reg == 7'(POOL_SLOTS)) begin
                        nxt_next = l_rd;
                        d_we = 1'b1; d_wd = ms_reg - raw_reg;
                        l_we = 1'b1; l_wa = cur_reg[AW-1:0]; l_wd = slot_reg;
                        state_next = ST_SFIX;
                    end
                end else begin
                    d_ra = nxt_reg[AW-1:0];
                    if ({1'b0, ms_reg} < sum) begin
                        d_we = 1'b1; d_wd = ms_reg - raw_reg;
                        l_we = 1'b1; l_wa = cur_reg[AW-1:0]; l_wd = slot_reg;
                        state_next = ST_SFIX;
                    end else begin
                        raw_next = sum[31:0];
                        cur_next = nxt_reg;
                        cnt_next = cnt_reg + 1'b1;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_SFIX: begin
                // link new slot to nxt, adjust delta of nxt
                l_we = 1'b1; l_wa = slot_reg[AW-1:0]; l_wd = nxt_reg;
                if (nxt_reg != Nil) begin
                    d_we = 1'b1; d_wa = nxt_reg[AW-1:0];
                    d_wd = d_rd - (ms_reg - raw_reg);
                end
                state_next = ST_REPLY;
            end
            ST_REPLY: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_TRD: begin
                state_next = ST_TCHK;
            end
            ST_TCHK: begin
                // d_rd/l_rd/t_rd belong to cur_reg
                if (cnt_reg == '0) begin
                    if (d_rd != '0) begin
                        d_we = 1'b1; d_wa = cur_reg[AW-1:0]; d_wd = d_rd - 32'd1;
                    end
                    if (d_rd == '0 || d_rd == 32'd1) begin
                        nxt_next = l_rd;
                        out_next = '{KindExpiry, StatusOk, 5'(cur_reg), t_rd, 1'b0};
                        state_next = ST_TOUT;
                    end else begin
                        state_next = ST_TWAIT;
                    end
                end else if (!ovalid_reg) begin
                    // release the staged beat; last unless this slot expires too
                    out_next.last = (d_rd != '0);
                    ovalid_next = 1'b1;
                    if (d_rd != '0) begin
                        state_next = ST_TWAIT;
                    end
                end else if (m_tready) begin
                    nxt_next = l_rd;
                    out_next = '{KindExpiry, StatusOk, 5'(cur_reg), t_rd, 1'b0};
                    state_next = ST_TOUT;
                end
            end
            ST_TOUT: begin
                l_we = 1'b1; l_wa = cur_reg[AW-1:0]; l_wd = fhead_reg;
                fhead_next = cur_reg;
                qhead_next = nxt_reg;
                cnt_next = cnt_reg + 1'b1;
                cur_next = nxt_reg;
                d_ra = nxt_reg[AW-1:0];
                l_ra = nxt_reg[AW-1:0];
                t_ra = nxt_reg[AW-1:0];
                if (nxt_reg == Nil || cnt_reg == 7'(MaxResults - 1)) begin
                    out_next.last = 1'b1;
                    ovalid_next = 1'b1;
                    state_next = ST_TWAIT;
                end else begin
                    state_next = ST_TCHK;
                end
            end
            ST_TWAIT: begin
                if (out_free || ovalid_reg) begin
                    state_next = ST_IDLE;
                end
                if (ovalid_reg && !m_tready) begin
                    state_next = ST_TWAIT;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_INIT;
            qhead_reg  <= Nil;
            fhead_reg  <= '0;
            cur_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            qhead_reg  <= qhead_next;
            fhead_reg  <= fhead_next;
            cur_reg    <= cur_next;
            ovalid_reg <= ovalid_next;
        end
        nxt_reg  <= nxt_next;
        slot_reg <= slot_next;
        ms_reg   <= ms_next;
        tag_reg  <= tag_next;
        raw_reg  <= raw_next;
        cnt_reg  <= cnt_next;
        out_reg  <= out_next;
    end

endmodule
